### rtl/sacta_pkg.sv
// ----------------------------------------------------------------------------
// sacta_pkg
// Shared types, codes and helpers for the set-associative cache tag array.
// ----------------------------------------------------------------------------
package sacta_pkg;

	localparam int unsigned SET_COUNT_DEF = 256;
	localparam int unsigned WAY_COUNT_DEF = 16;
	localparam int unsigned TAG_WIDTH_DEF = 32;

	localparam int ADDR_W     = 40;
	localparam int STAMP_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int OUT_WAY_W  = 4;
	localparam int OUT_TAG_W  = 32;
	localparam int LFSR_W     = 16;
	localparam int LFSR_CNT_W = 4;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTA = 2'd2;

	localparam logic [CFG_DATA_W-1:0] WAYS_RESET  = 5'd16;
	localparam logic [CFG_DATA_W-1:0] QUOTA_RESET = 5'd8;

	// replacement modes; the unused code falls back to LRU
	localparam logic [1:0] MODE_LRU    = 2'd0;
	localparam logic [1:0] MODE_RANDOM = 2'd1;
	localparam logic [1:0] MODE_PART   = 2'd2;

	localparam logic FUNC_LOOKUP  = 1'b0;
	localparam logic FUNC_INSTALL = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOD,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic clr_we;
		logic load;
		logic scan_step;
		logic lfsr_step;
		logic mod_step;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic need_mod;
		logic mod_last;
	} dp_stat_t;

	// Fibonacci LFSR, taps 16 14 13 11
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic fb;
		fb = v[0] ^ v[2] ^ v[3] ^ v[5];
		return {fb, v[LFSR_W-1:1]};
	endfunction

endpackage

### rtl/sacta_ctrl.sv
// ----------------------------------------------------------------------------
// sacta_ctrl
// Sequencer: clearing pass, way scan, optional random reduction, commit.
// ----------------------------------------------------------------------------
module sacta_ctrl import sacta_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (stat.need_mod) begin
					cmd.lfsr_step = 1'b1;
					state_d       = ST_MOD;
				end else begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### rtl/sacta_dp.sv
// ----------------------------------------------------------------------------
// sacta_dp
// Datapath: set row memories, way scanner, victim select, LFSR and remainder.
// ----------------------------------------------------------------------------
module sacta_dp import sacta_pkg::*; #(
	parameter int unsigned SET_COUNT = SET_COUNT_DEF,
	parameter int unsigned WAY_COUNT = WAY_COUNT_DEF,
	parameter int unsigned TAG_WIDTH = TAG_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  func,
	input  logic [ADDR_W-1:0]     line_address,
	input  logic                  write_access,
	input  logic                  requester_core,
	input  logic [STAMP_W-1:0]    access_time,
	output logic                  done,
	output logic                  hit,
	output logic [OUT_WAY_W-1:0]  victim_way,
	output logic                  evicted_valid,
	output logic                  evicted_dirty,
	output logic [OUT_TAG_W-1:0]  evicted_tag,
	output logic                  evicted_core,
	output logic                  dirty_eviction
);

	localparam int SB = $clog2(SET_COUNT);
	localparam int SW = (SB < 1) ? 1 : SB;
	localparam int WW = ($clog2(WAY_COUNT) < 1) ? 1 : $clog2(WAY_COUNT);
	localparam int NW = $clog2(WAY_COUNT + 1);

	// configuration
	logic [1:0]            mode_q;
	logic [CFG_DATA_W-1:0] ways_q, quota_q;
	logic [NW-1:0]         act_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LRU;
			ways_q  <= WAYS_RESET;
			quota_q <= QUOTA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[1:0];
				REG_WAYS:  ways_q  <= cfg_data;
				REG_QUOTA: quota_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ways_q == '0)                     act_n = NW'(1);
		else if (7'(ways_q) > 7'(WAY_COUNT)) act_n = NW'(WAY_COUNT);
		else                                  act_n = NW'(ways_q);
	end

	// captured item
	logic                 func_q, wr_q, core_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic [SW-1:0]        set_q;
	logic [STAMP_W-1:0]   now_q;
	logic [SW-1:0]        in_set;
	logic [TAG_WIDTH-1:0] in_tag;

	assign in_set = SW'(line_address & ADDR_W'(SET_COUNT - 1));
	assign in_tag = TAG_WIDTH'(line_address >> SB);

	// set row memories
	logic [WAY_COUNT-1:0]                val_mem   [SET_COUNT];
	logic [WAY_COUNT-1:0]                dirty_mem [SET_COUNT];
	logic [WAY_COUNT-1:0]                owner_mem [SET_COUNT];
	logic [WAY_COUNT-1:0][TAG_WIDTH-1:0] tag_mem   [SET_COUNT];
	logic [WAY_COUNT-1:0][STAMP_W-1:0]   stamp_mem [SET_COUNT];

	logic [WAY_COUNT-1:0]                rd_val_q, rd_dirty_q, rd_owner_q;
	logic [WAY_COUNT-1:0][TAG_WIDTH-1:0] rd_tag_q;
	logic [WAY_COUNT-1:0][STAMP_W-1:0]   rd_stamp_q;

	logic [WAY_COUNT-1:0]                wr_val, wr_dirty, wr_owner;
	logic [WAY_COUNT-1:0][TAG_WIDTH-1:0] wr_tag;
	logic [WAY_COUNT-1:0][STAMP_W-1:0]   wr_stamp;
	logic                                wr_en;
	logic [SW-1:0]                       clr_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_val_q   <= val_mem[in_set];
			rd_dirty_q <= dirty_mem[in_set];
			rd_owner_q <= owner_mem[in_set];
			rd_tag_q   <= tag_mem[in_set];
			rd_stamp_q <= stamp_mem[in_set];
		end
		if (cmd.clr_we) begin
			val_mem[clr_idx_q]   <= '0;
			dirty_mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			val_mem[set_q]   <= wr_val;
			dirty_mem[set_q] <= wr_dirty;
			owner_mem[set_q] <= wr_owner;
			tag_mem[set_q]   <= wr_tag;
			stamp_mem[set_q] <= wr_stamp;
		end
	end

	assign stat.clr_last = (clr_idx_q == SW'(SET_COUNT - 1));

	// scan trackers
	logic [WW-1:0]           idx_q, inv_way_q, hit_way_q, min_all_way_q;
	logic                    inv_found_q, hit_q;
	logic [NW-1:0]           count0_q;
	logic [STAMP_W-1:0]      min_all_q;
	logic [1:0][STAMP_W-1:0] min_own_q;
	logic [1:0][WW-1:0]      min_own_way_q;
	logic [1:0]              own_found_q;

	logic                    cur_v, cur_own;
	logic [TAG_WIDTH-1:0]    cur_tag;
	logic [STAMP_W-1:0]      cur_st;

	assign cur_v   = rd_val_q[idx_q];
	assign cur_own = rd_owner_q[idx_q];
	assign cur_tag = rd_tag_q[idx_q];
	assign cur_st  = rd_stamp_q[idx_q];

	assign stat.scan_last = ((NW + 1)'(idx_q) + (NW + 1)'(1)) == (NW + 1)'(act_n);

	// random reduction
	logic [LFSR_W-1:0]     lfsr_q, div_q;
	logic [NW-1:0]         rem_q;
	logic [NW:0]           rem_trial;
	logic [LFSR_CNT_W-1:0] mcnt_q;

	assign rem_trial     = {rem_q, div_q[LFSR_W-1]};
	assign stat.mod_last = (mcnt_q == LFSR_CNT_W'(LFSR_W - 1));
	assign stat.need_mod = (func_q == FUNC_INSTALL) && !inv_found_q && (mode_q == MODE_RANDOM);

	// victim choice
	logic          target;
	logic [WW-1:0] victim, sel;

	always_comb begin
		if (7'(count0_q) < 7'(quota_q))       target = 1'b1;
		else if (7'(count0_q) == 7'(quota_q)) target = core_q;
		else                                   target = 1'b0;
		if (inv_found_q) begin
			victim = inv_way_q;
		end else begin
			case (mode_q)
				MODE_RANDOM: victim = WW'(rem_q);
				MODE_PART:   victim = own_found_q[target] ? min_own_way_q[target] : '0;
				default:     victim = min_all_way_q;
			endcase
		end
		sel = (func_q == FUNC_INSTALL) ? victim : hit_way_q;
	end

	always_comb begin
		wr_val   = rd_val_q;
		wr_dirty = rd_dirty_q;
		wr_owner = rd_owner_q;
		wr_tag   = rd_tag_q;
		wr_stamp = rd_stamp_q;
		if (func_q == FUNC_INSTALL) begin
			wr_val[sel]   = 1'b1;
			wr_dirty[sel] = wr_q;
			wr_owner[sel] = core_q;
			wr_tag[sel]   = tag_q;
		end else begin
			wr_dirty[sel] = rd_dirty_q[sel] | wr_q;
		end
		wr_stamp[sel] = now_q;
	end

	assign wr_en = cmd.commit && ((func_q == FUNC_INSTALL) || hit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q      <= '0;
			func_q         <= FUNC_LOOKUP;
			wr_q           <= 1'b0;
			core_q         <= 1'b0;
			tag_q          <= '0;
			set_q          <= '0;
			now_q          <= '0;
			idx_q          <= '0;
			inv_way_q      <= '0;
			hit_way_q      <= '0;
			min_all_way_q  <= '0;
			inv_found_q    <= 1'b0;
			hit_q          <= 1'b0;
			count0_q       <= '0;
			min_all_q      <= '0;
			min_own_q      <= '0;
			min_own_way_q  <= '0;
			own_found_q    <= '0;
			lfsr_q         <= LFSR_SEED;
			div_q          <= '0;
			rem_q          <= '0;
			mcnt_q         <= '0;
			done           <= 1'b0;
			hit            <= 1'b0;
			victim_way     <= '0;
			evicted_valid  <= 1'b0;
			evicted_dirty  <= 1'b0;
			evicted_tag    <= '0;
			evicted_core   <= 1'b0;
			dirty_eviction <= 1'b0;
		end else begin
			done <= cmd.commit;
			if (cmd.clr_we) clr_idx_q <= clr_idx_q + 1'b1;
			if (cmd.load) begin
				func_q      <= func;
				wr_q        <= write_access;
				core_q      <= requester_core;
				tag_q       <= in_tag;
				set_q       <= in_set;
				now_q       <= access_time;
				idx_q       <= '0;
				inv_found_q <= 1'b0;
				hit_q       <= 1'b0;
				count0_q    <= '0;
				own_found_q <= '0;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (!cur_v && !inv_found_q) begin
					inv_found_q <= 1'b1;
					inv_way_q   <= idx_q;
				end
				if (cur_v && cur_tag == tag_q && cur_own == core_q && !hit_q) begin
					hit_q     <= 1'b1;
					hit_way_q <= idx_q;
				end
				if (!cur_own) count0_q <= count0_q + 1'b1;
				// strict compare: the earliest way wins a tie
				if (idx_q == '0 || cur_st < min_all_q) begin
					min_all_q     <= cur_st;
					min_all_way_q <= idx_q;
				end
				if (!own_found_q[cur_own] || cur_st < min_own_q[cur_own]) begin
					own_found_q[cur_own]   <= 1'b1;
					min_own_q[cur_own]     <= cur_st;
					min_own_way_q[cur_own] <= idx_q;
				end
			end
			if (cmd.lfsr_step) begin
				lfsr_q <= lfsr_next(lfsr_q);
				div_q  <= lfsr_next(lfsr_q);
				rem_q  <= '0;
				mcnt_q <= '0;
			end
			// restoring remainder, one dividend bit per cycle
			if (cmd.mod_step) begin
				div_q  <= div_q << 1;
				mcnt_q <= mcnt_q + 1'b1;
				if (rem_trial >= (NW + 1)'(act_n)) rem_q <= NW'(rem_trial - (NW + 1)'(act_n));
				else                                rem_q <= NW'(rem_trial);
			end
			if (cmd.commit) begin
				if (func_q == FUNC_INSTALL) begin
					hit            <= 1'b0;
					victim_way     <= OUT_WAY_W'(victim);
					evicted_valid  <= rd_val_q[victim];
					evicted_dirty  <= rd_val_q[victim] & rd_dirty_q[victim];
					evicted_tag    <= rd_val_q[victim] ? OUT_TAG_W'(rd_tag_q[victim]) : '0;
					evicted_core   <= rd_val_q[victim] & rd_owner_q[victim];
					dirty_eviction <= rd_val_q[victim] & rd_dirty_q[victim];
				end else begin
					hit            <= hit_q;
					victim_way     <= hit_q ? OUT_WAY_W'(hit_way_q) : '0;
					evicted_valid  <= 1'b0;
					evicted_dirty  <= 1'b0;
					evicted_tag    <= '0;
					evicted_core   <= 1'b0;
					dirty_eviction <= 1'b0;
				end
			end
		end
	end

endmodule

### rtl/set_assoc_cache_tag_array_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_array_unit
// Tag array of a two-core set-associative cache with LRU, random and
// partitioned replacement.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over all SET_COUNT sets with busy
// high. An item is taken when start is high and busy low; its set row is
// read in that cycle and the active ways (n) are then scanned one per cycle.
// A lookup, or an install that finds an invalid way or uses LRU or partition
// replacement, commits right after the scan; an install that needs a random
// victim first runs the bit-serial remainder unit and then commits. The
// result is shown for exactly one cycle with done high and must be taken
// then; the receiver cannot stall. A new item may start in the done cycle.
module set_assoc_cache_tag_array_unit import sacta_pkg::*; #(
	parameter int unsigned SET_COUNT = SET_COUNT_DEF,
	parameter int unsigned WAY_COUNT = WAY_COUNT_DEF,
	parameter int unsigned TAG_WIDTH = TAG_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [ADDR_W-1:0]     line_address,
	input  logic                  write_access,
	input  logic                  requester_core,
	input  logic [STAMP_W-1:0]    access_time,
	output logic                  done,
	output logic                  hit,
	output logic [OUT_WAY_W-1:0]  victim_way,
	output logic                  evicted_valid,
	output logic                  evicted_dirty,
	output logic [OUT_TAG_W-1:0]  evicted_tag,
	output logic                  evicted_core,
	output logic                  dirty_eviction
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sacta_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	sacta_dp #(
		.SET_COUNT(SET_COUNT),
		.WAY_COUNT(WAY_COUNT),
		.TAG_WIDTH(TAG_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.line_address  (line_address),
		.write_access  (write_access),
		.requester_core(requester_core),
		.access_time   (access_time),
		.done          (done),
		.hit           (hit),
		.victim_way    (victim_way),
		.evicted_valid (evicted_valid),
		.evicted_dirty (evicted_dirty),
		.evicted_tag   (evicted_tag),
		.evicted_core  (evicted_core),
		.dirty_eviction(dirty_eviction)
	);

endmodule

### rtl/sacta_checker.sv
// ----------------------------------------------------------------------------
// sacta_checker
// Port-level checks on the tag array unit's result timing and contents.
// ----------------------------------------------------------------------------
module sacta_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic hit,
	input logic evicted_valid,
	input logic evicted_dirty,
	input logic dirty_eviction
);

	// a result only closes work that held the unit busy
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("unit not busy after transfer");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (!evicted_valid && !dirty_eviction))
		else $error("hit reported with an eviction");

	a_dirty_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dirty_eviction) |-> (evicted_valid && evicted_dirty))
		else $error("writeback flagged for a clean or invalid line");

endmodule

bind set_assoc_cache_tag_array_unit sacta_checker u_sacta_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.evicted_valid (evicted_valid),
	.evicted_dirty (evicted_dirty),
	.dirty_eviction(dirty_eviction)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the set-associative cache tag array. A scoreboard
// keeps its own copy of the tag, owner, stamp and dirty state and of the
// replacement registers. It predicts every lookup and install result and
// compares each done strobe against the oldest prediction. Stimulus walks
// through several replacement settings with directed and random traffic.
// ----------------------------------------------------------------------------
import sacta_pkg::*;

typedef struct {
	logic        hit;
	logic [3:0]  way;
	logic        ev_valid;
	logic        ev_dirty;
	logic [31:0] ev_tag;
	logic        ev_core;
	logic        dirty_ev;
} tag_result_t;

class tag_scoreboard;
	bit          valid_q[4096];
	bit          dirty_q[4096];
	bit [31:0]   tag_q[4096];
	bit          owner_q[4096];
	bit [31:0]   stamp_q[4096];
	bit [15:0]   lfsr;
	bit [1:0]    mode;
	bit [4:0]    ways;
	bit [4:0]    quota;
	tag_result_t pending[$];
	int          mismatches;

	function new();
		lfsr = LFSR_SEED;
		mode = MODE_LRU;
		ways = WAYS_RESET;
		quota = QUOTA_RESET;
		mismatches = 0;
	endfunction

	function void set_reg(bit [1:0] idx, bit [4:0] val);
		if (idx == REG_MODE) mode = val[1:0];
		else if (idx == REG_WAYS) ways = val;
		else if (idx == REG_QUOTA) quota = val;
	endfunction

	function int pick_way(int base, int n, bit core);
		int count0;
		int victim;
		bit target;
		bit found;
		bit [31:0] best;
		count0 = 0;
		victim = 0;
		found = 0;
		for (int w = 0; w < n; w++)
			if (!valid_q[base + w]) return w;
		if (mode == MODE_RANDOM) begin
			lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
			return int'(lfsr) % n;
		end
		if (mode == MODE_PART) begin
			for (int w = 0; w < n; w++)
				if (!owner_q[base + w]) count0++;
			if (count0 < int'(quota)) target = 1;
			else if (count0 == int'(quota)) target = core;
			else target = 0;
			for (int w = 0; w < n; w++) begin
				if (owner_q[base + w] != target) continue;
				if (!found || stamp_q[base + w] < best) begin
					best = stamp_q[base + w];
					victim = w;
					found = 1;
				end
			end
			return victim;
		end
		best = stamp_q[base];
		for (int w = 1; w < n; w++)
			if (stamp_q[base + w] < best) begin
				best = stamp_q[base + w];
				victim = w;
			end
		return victim;
	endfunction

	// Predict one accepted transfer and queue its result.
	function void note_input(bit fn, bit [39:0] addr, bit wr, bit core, bit [31:0] now);
		tag_result_t r;
		int base;
		int n;
		int e;
		int w;
		bit [31:0] tag;
		r = '{default: 0};
		base = int'(addr[7:0]) * 16;
		tag = addr[39:8];
		n = (ways < 1) ? 1 : (ways > 16) ? 16 : int'(ways);
		if (fn == FUNC_LOOKUP) begin
			for (w = 0; w < n; w++) begin
				e = base + w;
				if (valid_q[e] && tag_q[e] == tag && owner_q[e] == core) begin
					if (wr) dirty_q[e] = 1;
					stamp_q[e] = now;
					r.hit = 1;
					r.way = w[3:0];
					break;
				end
			end
		end else begin
			w = pick_way(base, n, core);
			e = base + w;
			r.way = w[3:0];
			if (valid_q[e]) begin
				r.ev_valid = 1;
				r.ev_dirty = dirty_q[e];
				r.ev_tag = tag_q[e];
				r.ev_core = owner_q[e];
				r.dirty_ev = dirty_q[e];
			end
			valid_q[e] = 1;
			dirty_q[e] = wr;
			tag_q[e] = tag;
			owner_q[e] = core;
			stamp_q[e] = now;
		end
		pending.push_back(r);
	endfunction

	function void check_result(tag_result_t act);
		tag_result_t exp;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result strobe: act hit=%0d way=%0d tag=%h",
					act.hit, act.way, act.ev_tag);
			return;
		end
		exp = pending.pop_front();
		if (act.hit !== exp.hit || act.way !== exp.way || act.ev_valid !== exp.ev_valid ||
				act.ev_dirty !== exp.ev_dirty || act.ev_tag !== exp.ev_tag ||
				act.ev_core !== exp.ev_core || act.dirty_ev !== exp.dirty_ev) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result mismatch: exp hit=%0d way=%0d ev=%0d/%0d tag=%h core=%0d wb=%0d",
					exp.hit, exp.way, exp.ev_valid, exp.ev_dirty, exp.ev_tag, exp.ev_core,
					exp.dirty_ev);
				$display("                 act hit=%0d way=%0d ev=%0d/%0d tag=%h core=%0d wb=%0d",
					act.hit, act.way, act.ev_valid, act.ev_dirty, act.ev_tag, act.ev_core,
					act.dirty_ev);
			end
		end
	endfunction
endclass

module testbench;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  start = 0;
	logic                  busy;
	logic                  func = 0;
	logic [ADDR_W-1:0]     line_address = '0;
	logic                  write_access = 0;
	logic                  requester_core = 0;
	logic [STAMP_W-1:0]    access_time = '0;
	logic                  done;
	logic                  hit;
	logic [OUT_WAY_W-1:0]  victim_way;
	logic                  evicted_valid;
	logic                  evicted_dirty;
	logic [OUT_TAG_W-1:0]  evicted_tag;
	logic                  evicted_core;
	logic                  dirty_eviction;

	tag_scoreboard sb = new();
	bit            calm;
	bit [31:0]     clock_now;

	set_assoc_cache_tag_array_unit dut (.*);

	initial forever #6 clk = ~clk;

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && done === 1'b1)
			sb.check_result('{hit, victim_way, evicted_valid, evicted_dirty, evicted_tag,
				evicted_core, dirty_eviction});

	// Hold start until the transfer, then idle for a random gap.
	task automatic send(bit fn, bit [39:0] addr, bit wr, bit core, bit [31:0] now);
		int gap;
		start <= 1;
		func <= fn;
		line_address <= addr;
		write_access <= wr;
		requester_core <= core;
		access_time <= now;
		do @(posedge clk); while (busy);
		sb.note_input(fn, addr, wr, core, now);
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic configure(bit [1:0] m, bit [4:0] w, bit [4:0] q);
		drain();
		cfg_we <= 1;
		cfg_index <= REG_MODE;
		cfg_data <= {3'b0, m};
		@(posedge clk);
		sb.set_reg(REG_MODE, {3'b0, m});
		cfg_index <= REG_WAYS;
		cfg_data <= w;
		@(posedge clk);
		sb.set_reg(REG_WAYS, w);
		cfg_index <= REG_QUOTA;
		cfg_data <= q;
		@(posedge clk);
		sb.set_reg(REG_QUOTA, q);
		cfg_we <= 0;
	endtask

	// Lookup then, mostly, install the same line as a miss handler would.
	task automatic random_traffic(int count);
		bit [39:0] addr;
		bit [31:0] now;
		bit        core;
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0) calm = $urandom_range(0, 2) == 0;
			if ($urandom_range(0, 9) == 0)
				addr = 40'({$urandom, $urandom});
			else
				addr = {$urandom_range(0, 20), 2'b00, 3'd0, 3'($urandom_range(0, 2))} +
					({8'b0, $urandom} & 40'h0) + (40'($urandom_range(0, 1)) << 39);
			core = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0) now = $urandom_range(0, 7);
			else if ($urandom_range(0, 3) == 0) now = $urandom;
			else begin
				clock_now += $urandom_range(1, 4);
				now = clock_now;
			end
			if ($urandom_range(0, 9) < 8) begin
				send(FUNC_LOOKUP, addr, 1'($urandom_range(0, 1)), core, now);
				if ($urandom_range(0, 4) != 0)
					send(FUNC_INSTALL, addr, 1'($urandom_range(0, 1)), core, now);
			end else
				send(1'($urandom_range(0, 1)), addr, 1'($urandom_range(0, 1)), core, now);
		end
	endtask

	initial begin
		calm = 0;
		clock_now = 100;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		configure(MODE_LRU, 5'd16, 5'd8);
		// directed: extremes, hit paths and a full set with LRU eviction
		send(FUNC_LOOKUP, 40'h0, 1'b0, 1'b0, 32'h0);
		send(FUNC_INSTALL, 40'h0, 1'b1, 1'b0, 32'h0);
		send(FUNC_LOOKUP, 40'h0, 1'b1, 1'b0, 32'h5);
		send(FUNC_LOOKUP, 40'h0, 1'b0, 1'b1, 32'h6);
		send(FUNC_LOOKUP, 40'hFF_FFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send(FUNC_INSTALL, 40'hFF_FFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
		send(FUNC_LOOKUP, 40'hFF_FFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFE);
		for (int t = 0; t < 17; t++)
			send(FUNC_INSTALL, {32'(t * 7 + 1), 8'h05}, t[0], t[1], 32'(200 - t));
		configure(MODE_RANDOM, 5'd16, 5'd8);
		random_traffic(60);
		configure(MODE_PART, 5'd16, 5'd0);
		random_traffic(60);
		configure(MODE_PART, 5'd16, 5'd16);
		random_traffic(50);
		configure(MODE_PART, 5'd4, 5'd2);
		random_traffic(60);
		configure(MODE_LRU, 5'd1, 5'd0);
		random_traffic(40);
		configure(MODE_RANDOM, 5'd0, 5'd31);
		random_traffic(40);
		configure(MODE_SPARE, 5'd31, 5'd5);
		random_traffic(50);
		configure(MODE_PART, 5'd8, 5'd31);
		random_traffic(50);
		configure(MODE_RANDOM, 5'd5, 5'd3);
		random_traffic(50);
		configure(MODE_PART, 5'd16, 5'd8);
		random_traffic(60);
		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
